@@ hw/rtl/ffdx_pkg.sv @@
// Shared types and constants of the frame deframer with XOR checksum.
// Used by ffdx_parser, ffdx_emitter and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ffdx_pkg;

    localparam int DATA_W          = 8;
    localparam int LEN_W           = 6;
    localparam int IDX_W           = 5;
    localparam int KIND_W          = 3;
    localparam int CFG_IDX_W       = 2;
    localparam int IN_TDATA_W      = 8;
    localparam int OUT_TDATA_W     = 32;
    localparam int MAX_PAYLOAD_DEF = 32;

    localparam logic [DATA_W-1:0] HEADER_RESET = 8'd170;
    localparam logic [DATA_W-1:0] TAIL_RESET   = 8'd85;
    localparam logic [LEN_W-1:0]  LIMIT_RESET  = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER = 2'd0,
        CFG_TAIL   = 2'd1,
        CFG_LIMIT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_MSG        = 3'd0,
        KIND_BAD_HEADER = 3'd1,
        KIND_BAD_LENGTH = 3'd2,
        KIND_BAD_CHECK  = 3'd3,
        KIND_BAD_TAIL   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COMMAND = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_TAIL    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EM_IDLE   = 2'd0,
        EM_SINGLE = 2'd1,
        EM_READ   = 2'd2,
        EM_WRITE  = 2'd3
    } em_state_t;

    typedef struct packed {
        logic              valid;
        kind_t             kind;
        logic [DATA_W-1:0] command;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] value;
    } job_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffdx_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ffdx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ffdx_parser.sv @@
// Frame parser: phase machine, running XOR, payload writes into the RAM.
// Issues one job per error or good tail to the emitter. Uses ffdx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffdx_parser #(
    parameter int MAX_PAYLOAD = ffdx_pkg::MAX_PAYLOAD_DEF,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [ffdx_pkg::DATA_W-1:0] in_byte,
    input  wire logic [ffdx_pkg::DATA_W-1:0] header_value,
    input  wire logic [ffdx_pkg::DATA_W-1:0] tail_value,
    input  wire logic [ffdx_pkg::LEN_W-1:0]  payload_limit,
    output ffdx_pkg::job_t                   job,
    output logic                             ram_we,
    output logic      [AW-1:0]               ram_waddr,
    output logic      [ffdx_pkg::DATA_W-1:0] ram_wdata
);
    import ffdx_pkg::*;

    localparam logic [DATA_W-1:0] MAX_P = DATA_W'(MAX_PAYLOAD);

    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] cmd_reg, cmd_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [DATA_W-1:0] xor_reg, xor_next;
    logic [DATA_W-1:0] limit;
    logic              len_bad;
    logic              fill_done;
    logic [LEN_W:0]    fill_inc;

    assign limit     = ({2'b00, payload_limit} > MAX_P) ? MAX_P : {2'b00, payload_limit};
    assign len_bad   = in_byte > limit;
    assign fill_inc  = {1'b0, fill_reg} + 1'b1;
    assign fill_done = fill_inc >= {1'b0, len_reg};

    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (phase_reg)
                PH_COMMAND: phase_next = PH_LENGTH;
                PH_LENGTH: begin
                    if (len_bad) begin
                        phase_next = PH_HEADER;
                    end else if (in_byte == '0) begin
                        phase_next = PH_CHECK;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (fill_done) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:   phase_next = (in_byte != xor_reg) ? PH_HEADER : PH_TAIL;
                PH_TAIL:    phase_next = PH_HEADER;
                default:    phase_next = (in_byte == header_value) ? PH_COMMAND : PH_HEADER;
            endcase
        end
    end

    always_comb begin
        job         = '0;
        job.kind    = KIND_MSG;
        job.value   = in_byte;
        ram_we      = 1'b0;
        ram_waddr   = fill_reg[AW-1:0];
        ram_wdata   = in_byte;
        if (accept) begin
            case (phase_reg)
                PH_COMMAND: ;
                PH_LENGTH: begin
                    if (len_bad) begin
                        job.valid = 1'b1;
                        job.kind  = KIND_BAD_LENGTH;
                    end
                end
                PH_PAYLOAD: ram_we = 1'b1;
                PH_CHECK: begin
                    if (in_byte != xor_reg) begin
                        job.valid = 1'b1;
                        job.kind  = KIND_BAD_CHECK;
                    end
                end
                PH_TAIL: begin
                    job.valid = 1'b1;
                    if (in_byte != tail_value) begin
                        job.kind = KIND_BAD_TAIL;
                    end else begin
                        job.kind    = KIND_MSG;
                        job.command = cmd_reg;
                        job.length  = len_reg;
                        job.value   = '0;
                    end
                end
                default: begin
                    if (in_byte != header_value) begin
                        job.valid = 1'b1;
                        job.kind  = KIND_BAD_HEADER;
                    end
                end
            endcase
        end
    end

    always_comb begin
        cmd_next  = cmd_reg;
        len_next  = len_reg;
        fill_next = fill_reg;
        xor_next  = xor_reg;
        if (accept) begin
            case (phase_reg)
                PH_COMMAND: begin
                    cmd_next = in_byte;
                    xor_next = in_byte;
                end
                PH_LENGTH: begin
                    xor_next = xor_reg ^ in_byte;
                    if (!len_bad) begin
                        len_next  = in_byte[LEN_W-1:0];
                        fill_next = '0;
                    end
                end
                PH_PAYLOAD: begin
                    fill_next = fill_inc[LEN_W-1:0];
                    xor_next  = xor_reg ^ in_byte;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cmd_reg   <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            xor_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ffdx_emitter.sv @@
// Result emitter: latches a job, drains payload bytes from the RAM and
// drives the output register of the m_ channel. Uses ffdx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffdx_emitter #(
    parameter int MAX_PAYLOAD = ffdx_pkg::MAX_PAYLOAD_DEF,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ffdx_pkg::job_t              job,
    output logic                             busy,
    output logic                             ram_re,
    output logic      [AW-1:0]               ram_raddr,
    input  wire logic [ffdx_pkg::DATA_W-1:0] ram_rdata,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ffdx_pkg::kind_t                  out_kind,
    output logic      [ffdx_pkg::DATA_W-1:0] out_command,
    output logic      [ffdx_pkg::LEN_W-1:0]  out_length,
    output logic      [ffdx_pkg::IDX_W-1:0]  out_index,
    output logic      [ffdx_pkg::DATA_W-1:0] out_value,
    output logic                             out_last
);
    import ffdx_pkg::*;

    em_state_t        state_reg, state_next;
    job_t             job_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic [LEN_W:0]   idx_inc;
    logic             last_byte;
    logic             out_free;
    logic             take_job;
    logic             load_single;
    logic             load_byte;
    logic             valid_reg, valid_next;

    assign out_free  = !valid_reg || out_ready;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign last_byte = idx_inc == {1'b0, job_reg.length};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EM_IDLE: begin
                if (job.valid) begin
                    state_next = (job.kind == KIND_MSG && job.length != '0) ? EM_READ
                                                                           : EM_SINGLE;
                end
            end
            EM_SINGLE: begin
                if (out_free) begin
                    state_next = EM_IDLE;
                end
            end
            EM_READ: state_next = EM_WRITE;
            EM_WRITE: begin
                if (out_free) begin
                    state_next = last_byte ? EM_IDLE : EM_READ;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    always_comb begin
        busy        = state_reg != EM_IDLE;
        take_job    = (state_reg == EM_IDLE) && job.valid;
        ram_re      = state_reg == EM_READ;
        ram_raddr   = idx_reg[AW-1:0];
        load_single = (state_reg == EM_SINGLE) && out_free;
        load_byte   = (state_reg == EM_WRITE) && out_free;
    end

    always_comb begin
        idx_next = idx_reg;
        if (take_job) begin
            idx_next = '0;
        end else if (load_byte) begin
            idx_next = idx_inc[LEN_W-1:0];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load_single || load_byte) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (take_job) begin
            job_reg <= job;
        end
        if (load_single) begin
            out_kind    <= job_reg.kind;
            out_command <= job_reg.command;
            out_length  <= job_reg.length;
            out_index   <= '0;
            out_value   <= job_reg.value;
            out_last    <= 1'b1;
        end else if (load_byte) begin
            out_kind    <= KIND_MSG;
            out_command <= job_reg.command;
            out_length  <= job_reg.length;
            out_index   <= idx_reg[IDX_W-1:0];
            out_value   <= ram_rdata;
            out_last    <= last_byte;
        end
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/frame_deframer_xor_checksum_unit.sv @@
// Top level of the frame deframer with XOR checksum: config registers,
// parser, payload RAM and result emitter. Uses ffdx_pkg, ffdx_ram,
// ffdx_parser and ffdx_emitter.
`timescale 1ns / 1ps
`default_nettype none

// Frame bytes (header, command, length, payload, checksum, tail) are taken one
// per cycle while the emitter is idle; payload bytes go into a RAM of
// MAX_PAYLOAD bytes. An error result (bad header, length, checksum or tail)
// or an empty message holds off input until the emitter has loaded it into
// the output register. A good tail drains the payload out of the RAM's
// single read port one byte at a time (read, then load into the output
// register), and input stays stopped until the last byte is loaded; each
// result word also waits for m_tready. The output register lets a new byte be
// accepted while the last result word of a run is still waiting.
module frame_deframer_xor_checksum_unit #(
    parameter int MAX_PAYLOAD = ffdx_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ffdx_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ffdx_pkg::DATA_W-1:0]       cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ffdx_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] in_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] command, [13:8] msg_length, [18:14] byte_index, [26:19] value,
    // [31:27] zero
    output logic      [ffdx_pkg::OUT_TDATA_W-1:0]  m_tdata,
    output logic      [ffdx_pkg::KIND_W-1:0]       m_tuser,   // [2:0] kind
    output logic                                   m_tlast
);
    import ffdx_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [DATA_W-1:0] header_reg;
    logic [DATA_W-1:0] tail_reg;
    logic [LEN_W-1:0]  limit_reg;
    logic              in_accept;
    logic              em_busy;
    job_t              job;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    kind_t             out_kind;
    logic [DATA_W-1:0] out_command;
    logic [LEN_W-1:0]  out_length;
    logic [IDX_W-1:0]  out_index;
    logic [DATA_W-1:0] out_value;

    assign cfg_ready = 1'b1;
    assign s_tready  = !em_busy;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            tail_reg   <= TAIL_RESET;
            limit_reg  <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data;
                CFG_TAIL:   tail_reg   <= cfg_data;
                CFG_LIMIT:  limit_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    ffdx_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (in_accept),
        .in_byte       (s_tdata[DATA_W-1:0]),
        .header_value  (header_reg),
        .tail_value    (tail_reg),
        .payload_limit (limit_reg),
        .job           (job),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    ffdx_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_PAYLOAD)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ffdx_emitter #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job         (job),
        .busy        (em_busy),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (out_kind),
        .out_command (out_command),
        .out_length  (out_length),
        .out_index   (out_index),
        .out_value   (out_value),
        .out_last    (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {{(OUT_TDATA_W - 2*DATA_W - LEN_W - IDX_W){1'b0}},
                      out_value, out_index, out_length, out_command};

    a_no_write_while_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        em_busy |-> !ram_we)
        else $error("payload write while emitter busy");

    a_error_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_kind != KIND_MSG) |-> m_tlast)
        else $error("error result without last");

    a_job_only_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job.valid |-> !$past(em_busy) || !em_busy)
        else $error("job issued while emitter busy");

    a_busy_after_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job.valid |=> em_busy && !s_tready)
        else $error("emitter did not take job");

endmodule

`default_nettype wire
